// ===== rtl/ata_pkg.sv =====
package ata_pkg;

    localparam int TABLE_LEN = 24;
    localparam int ROOT_W    = 25;
    localparam int CW        = 28;
    localparam int ACC_W     = 24;

    typedef logic [ROOT_W-1:0] root_t;

    // Per-lane request and result bundles.
    typedef struct packed {
        logic [ROOT_W-1:0] num;
        logic [ROOT_W-1:0] den;
        logic              negative;
    } lane_req_t;

    typedef struct packed {
        logic signed [14:0] angle;
        logic               undef;
    } lane_res_t;

    function automatic logic [ACC_W-1:0] atan_entry(input logic [4:0] i);
        logic [ACC_W-1:0] r;
        begin
            case (i)
                5'd0:  r = 24'd2949120;
                5'd1:  r = 24'd1740967;
                5'd2:  r = 24'd919879;
                5'd3:  r = 24'd466945;
                5'd4:  r = 24'd234379;
                5'd5:  r = 24'd117304;
                5'd6:  r = 24'd58666;
                5'd7:  r = 24'd29335;
                5'd8:  r = 24'd14668;
                5'd9:  r = 24'd7334;
                5'd10: r = 24'd3667;
                5'd11: r = 24'd1833;
                5'd12: r = 24'd917;
                5'd13: r = 24'd458;
                5'd14: r = 24'd229;
                5'd15: r = 24'd115;
                5'd16: r = 24'd57;
                5'd17: r = 24'd29;
                5'd18: r = 24'd14;
                5'd19: r = 24'd7;
                5'd20: r = 24'd4;
                5'd21: r = 24'd2;
                5'd22: r = 24'd1;
                default: r = 24'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/ata_if.sv =====
interface ata_in_if;
    logic              valid;
    logic              ready;
    logic [7:0]        status_byte;
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_z;
    modport source (output valid, status_byte, sample_x, sample_y, sample_z, input ready);
    modport sink   (input valid, status_byte, sample_x, sample_y, sample_z, output ready);
endinterface

interface ata_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] tilt_x;
    logic signed [14:0] tilt_y;
    logic signed [14:0] tilt_z;
    logic [2:0]         undefined_mask;
    logic               fresh;
    modport source (output valid, tilt_x, tilt_y, tilt_z, undefined_mask, fresh,
                    input ready);
    modport sink   (input valid, tilt_x, tilt_y, tilt_z, undefined_mask, fresh,
                    output ready);
endinterface

// ===== rtl/accel_tilt_angles_core.sv =====
// Channel  | Dir | Payload
// in_ch    | in  | status_byte, sample_x, sample_y, sample_z
// out_ch   | out | tilt_x, tilt_y, tilt_z, undefined_mask, fresh
//
// With RUN = min(CORDIC_STEPS, 24), an accepted request has its samples latched,
// then runs through 25 square-root passes and RUN CORDIC rotations, and is
// merged into the output register. The next request is accepted only once the
// core is back in idle, so no new request is taken while one is in flight.
// A result waiting in the output register does not block the input; a second
// finished result waits in the hold state and stalls the input until the
// output register drains. Reset clears the held samples to zero and empties
// the lanes and the output register.
module accel_tilt_angles_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    ata_in_if.sink        in_ch,
    ata_out_if.source     out_ch
);
    typedef enum logic [1:0] { S_IDLE, S_ROOT, S_CORDIC, S_HOLD } state_t;

    state_t              state_reg;
    logic signed [15:0]  hx_reg, hy_reg, hz_reg;
    logic                fresh_reg;
    logic                kick_reg;
    logic                ovalid_reg;
    logic signed [14:0]  otx_reg, oty_reg, otz_reg;
    logic [2:0]          oum_reg;
    logic                ofresh_reg;

    logic                accept, new_samples, load_out;
    logic signed [15:0]  nx, ny, nz;
    logic [15:0]         ax, ay, az;
    logic [2:0]          root_done, lane_done;
    ata_pkg::root_t      r_yz, r_xz, r_xy;
    ata_pkg::lane_req_t  req_x, req_y, req_z;
    ata_pkg::lane_res_t  res_x, res_y, res_z;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign new_samples = (in_ch.status_byte & 8'h03) != 8'h00;
    assign nx = (accept && new_samples) ? in_ch.sample_x : hx_reg;
    assign ny = (accept && new_samples) ? in_ch.sample_y : hy_reg;
    assign nz = (accept && new_samples) ? in_ch.sample_z : hz_reg;

    // The merged result moves into the output register once it is free.
    assign load_out = (state_reg == S_HOLD) && (!ovalid_reg || out_ch.ready);

    // Magnitudes of the held triple; 16 bits hold |-32768|.
    assign ax = hx_reg[15] ? 16'(-hx_reg) : hx_reg;
    assign ay = hy_reg[15] ? 16'(-hy_reg) : hy_reg;
    assign az = hz_reg[15] ? 16'(-hz_reg) : hz_reg;

    // The root units start in the cycle after acceptance, once the held
    // registers carry the triple for this request.
    ata_root u_root_yz (.clk, .rst_n, .start(kick_reg), .mag_a(ay), .mag_b(az),
                        .done(root_done[0]), .root(r_yz));
    ata_root u_root_xz (.clk, .rst_n, .start(kick_reg), .mag_a(ax), .mag_b(az),
                        .done(root_done[1]), .root(r_xz));
    ata_root u_root_xy (.clk, .rst_n, .start(kick_reg), .mag_a(ax), .mag_b(ay),
                        .done(root_done[2]), .root(r_xy));

    assign req_x = '{num: {1'b0, ax, 8'd0}, den: r_yz, negative: hx_reg[15]};
    assign req_y = '{num: {1'b0, ay, 8'd0}, den: r_xz, negative: hy_reg[15]};
    assign req_z = '{num: r_xy, den: {1'b0, az, 8'd0}, negative: hz_reg[15]};

    ata_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_x
        (.clk, .rst_n, .start(root_done[0]), .req(req_x), .done(lane_done[0]), .res(res_x));
    ata_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_y
        (.clk, .rst_n, .start(root_done[1]), .req(req_y), .done(lane_done[1]), .res(res_y));
    ata_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_z
        (.clk, .rst_n, .start(root_done[2]), .req(req_z), .done(lane_done[2]), .res(res_z));

    // State, held samples and the merging output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            hx_reg     <= '0;
            hy_reg     <= '0;
            hz_reg     <= '0;
            fresh_reg  <= 1'b0;
            kick_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            otx_reg    <= '0;
            oty_reg    <= '0;
            otz_reg    <= '0;
            oum_reg    <= '0;
            ofresh_reg <= 1'b0;
        end
        else
        begin
            kick_reg <= accept;
            if (load_out)
                ovalid_reg <= 1'b1;
            else if (out_ch.valid && out_ch.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        hx_reg    <= nx;
                        hy_reg    <= ny;
                        hz_reg    <= nz;
                        fresh_reg <= new_samples;
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (root_done[0])
                        state_reg <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (lane_done[0])
                        state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    if (load_out)
                    begin
                        otx_reg    <= res_x.angle;
                        oty_reg    <= res_y.angle;
                        otz_reg    <= res_z.angle;
                        oum_reg    <= {res_z.undef, res_y.undef, res_x.undef};
                        ofresh_reg <= fresh_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid          = ovalid_reg;
    assign out_ch.tilt_x         = otx_reg;
    assign out_ch.tilt_y         = oty_reg;
    assign out_ch.tilt_z         = otz_reg;
    assign out_ch.undefined_mask = oum_reg;
    assign out_ch.fresh          = ofresh_reg;

    // The three lanes run in lockstep, so their done pulses coincide.
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        lane_done[0] |-> (lane_done[1] && lane_done[2]))
        else $error("lanes out of step");
    a_roots_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        root_done[0] |-> (root_done[1] && root_done[2]))
        else $error("root units out of step");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !accept)
        else $error("request accepted while busy");
    a_done_in_cordic: assert property (@(posedge clk) disable iff (!rst_n)
        lane_done[0] |-> (state_reg == S_CORDIC))
        else $error("lane finished outside cordic phase");
endmodule

// ===== rtl/ata_root.sv =====
// Bit-serial integer square root of (a^2 + b^2) << 16, one result bit per
// pass of the restoring loop, one pass per cycle.
module ata_root (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [15:0]               mag_a,
    input  logic [15:0]               mag_b,
    output logic                      done,
    output logic [ata_pkg::ROOT_W-1:0] root
);
    localparam int NW = 50;

    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] res_reg, res_next;
    logic [NW-1:0] bit_reg, bit_next;
    logic          busy_reg, busy_next;
    logic [NW-1:0] trial;
    logic [31:0]   sq_a, sq_b;
    logic [32:0]   sum_sq;

    assign sq_a   = mag_a * mag_a;
    assign sq_b   = mag_b * mag_b;
    assign sum_sq = {1'b0, sq_a} + {1'b0, sq_b};
    assign trial  = res_reg + bit_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = {1'b0, sum_sq, 16'd0};
            res_next  = '0;
            bit_next  = {2'b01, {(NW-2){1'b0}}};
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[1:0] != 2'b00)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rem_reg  <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            rem_reg  <= rem_next;
            res_reg  <= res_next;
            bit_reg  <= bit_next;
        end
    end

    assign done = busy_reg && (bit_reg[1:0] != 2'b00);
    assign root = res_next[ata_pkg::ROOT_W-1:0];
endmodule

// ===== rtl/ata_lane.sv =====
// One CORDIC vectoring lane, one micro-rotation per cycle.
module ata_lane #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ata_pkg::lane_req_t   req,
    output logic                 done,
    output ata_pkg::lane_res_t   res
);
    localparam int RUN = (CORDIC_STEPS < ata_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                              : ata_pkg::TABLE_LEN;
    localparam int CW = ata_pkg::CW;
    localparam int AW = ata_pkg::ACC_W + 2;

    logic signed [CW-1:0] cx_reg, cy_reg, cx_next, cy_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [4:0]           step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 fin_reg, fin_next;
    ata_pkg::lane_req_t   req_reg, req_next;
    logic signed [CW-1:0] dx, dy;
    logic signed [AW-1:0] tab;
    logic signed [AW-1:0] clamped;
    logic [AW+7:0]        scaled;
    logic [14:0]          mag;

    assign dx  = cx_reg >>> step_reg;
    assign dy  = cy_reg >>> step_reg;
    assign tab = $signed({2'b00, ata_pkg::atan_entry(step_reg)});

    always_comb
    begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        req_next  = req_reg;
        fin_next  = 1'b0;
        if (start)
        begin
            req_next  = req;
            cx_next   = $signed({{(CW-ata_pkg::ROOT_W){1'b0}}, req.den});
            cy_next   = $signed({{(CW-ata_pkg::ROOT_W){1'b0}}, req.num});
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!cy_reg[CW-1])
            begin
                cx_next  = cx_reg + dy;
                cy_next  = cy_reg - dx;
                acc_next = acc_reg + tab;
            end
            else
            begin
                cx_next  = cx_reg - dy;
                cy_next  = cy_reg + dx;
                acc_next = acc_reg - tab;
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(RUN - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            step_reg <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            acc_reg  <= '0;
            req_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            step_reg <= step_next;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            acc_reg  <= acc_next;
            req_reg  <= req_next;
        end
    end

    always_comb
    begin
        if (acc_reg[AW-1])
            clamped = '0;
        else if (acc_reg > AW'(90 * 65536))
            clamped = AW'(90 * 65536);
        else
            clamped = acc_reg;
        scaled = ({8'd0, clamped} * (AW+8)'(100)) + (AW+8)'(32768);
        mag    = scaled[30:16];
        res.undef = 1'b0;
        if (req_reg.num == '0)
        begin
            res.angle = '0;
            res.undef = (req_reg.den == '0);
        end
        else
        begin
            if (req_reg.den == '0)
                mag = 15'd9000;
            res.angle = req_reg.negative ? -$signed(mag) : $signed(mag);
        end
    end

    assign done = fin_reg;
endmodule
